// ===== sv/obm_pkg.sv =====
// shared types and constants for the one-wire bus master
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package obm_pkg;

    localparam int REG_W         = 10;
    localparam int REG_COUNT     = 6;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = 3;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 5;

    // register indexes
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_PRESENCE_REC  = 3'd2;
    localparam logic [2:0] REG_SHORT         = 3'd3;
    localparam logic [2:0] REG_LONG          = 3'd4;
    localparam logic [2:0] REG_WR1_RELEASE   = 3'd5;

    // register reset values
    localparam logic [REG_W-1:0] RST_RESET_LOW     = 10'd480;
    localparam logic [REG_W-1:0] RST_PRESENCE_WAIT = 10'd70;
    localparam logic [REG_W-1:0] RST_PRESENCE_REC  = 10'd410;
    localparam logic [REG_W-1:0] RST_SHORT         = 10'd10;
    localparam logic [REG_W-1:0] RST_LONG          = 10'd60;
    localparam logic [REG_W-1:0] RST_WR1_RELEASE   = 10'd70;

    typedef struct packed {
        logic [REG_W-1:0] reset_low_time;
        logic [REG_W-1:0] presence_wait_time;
        logic [REG_W-1:0] presence_recover_time;
        logic [REG_W-1:0] short_time;
        logic [REG_W-1:0] long_time;
        logic [REG_W-1:0] write_one_release_time;
    } t_cfg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       presence_found;
        logic       done_res;
        logic       busy_res;
        logic       line_release;
    } t_res;

endpackage

`default_nettype wire

// ===== sv/obm_cfg_regs.sv =====
// apb register file holding the bus timing registers
// depends on obm_pkg
`timescale 1ns / 1ps
`default_nettype none

module obm_cfg_regs
    import obm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time         <= RST_RESET_LOW;
            r_cfg.presence_wait_time     <= RST_PRESENCE_WAIT;
            r_cfg.presence_recover_time  <= RST_PRESENCE_REC;
            r_cfg.short_time             <= RST_SHORT;
            r_cfg.long_time              <= RST_LONG;
            r_cfg.write_one_release_time <= RST_WR1_RELEASE;
        end else if (wr_en) begin
            case (idx)
                REG_RESET_LOW:     r_cfg.reset_low_time         <= pwdata[REG_W-1:0];
                REG_PRESENCE_WAIT: r_cfg.presence_wait_time     <= pwdata[REG_W-1:0];
                REG_PRESENCE_REC:  r_cfg.presence_recover_time  <= pwdata[REG_W-1:0];
                REG_SHORT:         r_cfg.short_time             <= pwdata[REG_W-1:0];
                REG_LONG:          r_cfg.long_time              <= pwdata[REG_W-1:0];
                REG_WR1_RELEASE:   r_cfg.write_one_release_time <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_RESET_LOW:     prdata = APB_DATA_W'(r_cfg.reset_low_time);
            REG_PRESENCE_WAIT: prdata = APB_DATA_W'(r_cfg.presence_wait_time);
            REG_PRESENCE_REC:  prdata = APB_DATA_W'(r_cfg.presence_recover_time);
            REG_SHORT:         prdata = APB_DATA_W'(r_cfg.short_time);
            REG_LONG:          prdata = APB_DATA_W'(r_cfg.long_time);
            REG_WR1_RELEASE:   prdata = APB_DATA_W'(r_cfg.write_one_release_time);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/onewire_bus_master_top.sv =====
// one-wire bus master top level: tick stream in, drive and status stream out
// depends on obm_pkg and obm_cfg_regs
`timescale 1ns / 1ps
`default_nettype none

// Every request on the input stream is one microsecond of bus time and gives
// exactly one response on the output stream, carrying the open-drain drive
// and the operation status for that tick. The response is computed in the
// cycle the request is offered, registered at the accepting edge and offered
// from the next cycle on, so one request per clock is sustained. The only
// limit is the single output register: while it holds a response that the
// downstream side has not taken, input is stalled, and a new request is
// accepted in the same cycle the held response is taken. The user must write
// timing registers via the apb port only while no operation runs; the block never checks.
module onewire_bus_master_top
    import obm_pkg::*;
#(
    parameter int TIMER_WIDTH = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,  // tx_byte, line_level
    input  wire logic [1:0]            s_axis_tuser,  // command
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [15:0]           m_axis_tdata,  // line_release, busy_res,
                                                      // done_res, presence_found, rx_byte
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int LW = ((TIMER_WIDTH > REG_W) ? TIMER_WIDTH : REG_W) + 1;
    localparam logic [LW-1:0] TICK_LIMIT = LW'(1) << TIMER_WIDTH;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_REC  = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_REL   = 4'd5;
    localparam logic [3:0] PH_RD_LOW   = 4'd6;
    localparam logic [3:0] PH_RD_WAIT  = 4'd7;
    localparam logic [3:0] PH_RD_REC   = 4'd8;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

    t_cfg cfg;

    obm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [3:0]             r_phase,   n_phase;
    logic [TIMER_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [BIT_IDX_W-1:0]   r_bit,     n_bit;
    logic [7:0]             r_shift,   n_shift;
    logic [1:0]             r_op,      n_op;
    logic                   r_pres,    n_pres;
    logic                   r_out_valid;
    t_res                   r_out,     n_out;

    logic       accept;
    logic [1:0] cmd;
    logic [7:0] tx_byte;
    logic       line_level;

    assign cmd        = s_axis_tuser;
    assign tx_byte    = s_axis_tdata[7:0];
    assign line_level = s_axis_tdata[8];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out};

    function automatic logic [LW-1:0] clip_time(input logic [REG_W-1:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        if (v == '0) begin
            w = LW'(1);
        end else if (w > TICK_LIMIT) begin
            w = TICK_LIMIT;
        end
        return w;
    endfunction

    always_comb begin
        logic [3:0]       ph;
        logic [REG_W-1:0] sel;
        logic [LW-1:0]    len;
        logic             done;
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_op      = r_op;
        n_pres    = r_pres;
        n_out     = '0;
        n_out.line_release = 1'b1;
        ph   = r_phase;
        sel  = '0;
        len  = '0;
        done = 1'b0;
        if (!(r_phase == PH_IDLE && cmd == OP_NONE)) begin
            // start of an operation, its first tick is already a low tick
            if (r_phase == PH_IDLE) begin
                n_op      = cmd;
                n_elapsed = '0;
                n_bit     = '0;
                case (cmd)
                    OP_RESET: begin
                        n_pres  = 1'b0;
                        n_shift = '0;
                        ph      = PH_RST_LOW;
                    end
                    OP_WRITE: begin
                        n_shift = tx_byte;
                        ph      = PH_WR_LOW;
                    end
                    default: begin
                        n_shift = '0;
                        ph      = PH_RD_LOW;
                    end
                endcase
            end

            n_out.line_release = !(ph == PH_RST_LOW || ph == PH_WR_LOW || ph == PH_RD_LOW);

            // sample on the first recovery tick
            if (n_elapsed == '0) begin
                if (ph == PH_RST_REC) begin
                    n_pres = !line_level;
                end else if (ph == PH_RD_REC) begin
                    n_shift = {line_level, n_shift[7:1]};
                end
            end

            case (ph)
                PH_RST_LOW:  sel = cfg.reset_low_time;
                PH_RST_WAIT: sel = cfg.presence_wait_time;
                PH_RST_REC:  sel = cfg.presence_recover_time;
                PH_WR_LOW:   sel = n_shift[0] ? cfg.short_time : cfg.long_time;
                PH_WR_REL:   sel = n_shift[0] ? cfg.write_one_release_time : cfg.short_time;
                PH_RD_LOW:   sel = cfg.short_time;
                PH_RD_WAIT:  sel = cfg.short_time;
                PH_RD_REC:   sel = cfg.long_time;
                default:     sel = 10'd1;
            endcase
            len = clip_time(sel);

            if (LW'(n_elapsed) + LW'(1) >= len) begin
                n_elapsed = '0;
                case (ph)
                    PH_RST_LOW:  ph = PH_RST_WAIT;
                    PH_RST_WAIT: ph = PH_RST_REC;
                    PH_RST_REC:  done = 1'b1;
                    PH_WR_LOW:   ph = PH_WR_REL;
                    PH_WR_REL: begin
                        n_shift = {1'b0, n_shift[7:1]};
                        if (n_bit == LAST_BIT) begin
                            done = 1'b1;
                        end else begin
                            n_bit = n_bit + 1'b1;
                            ph    = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW:   ph = PH_RD_WAIT;
                    PH_RD_WAIT:  ph = PH_RD_REC;
                    PH_RD_REC: begin
                        if (n_bit == LAST_BIT) begin
                            done = 1'b1;
                        end else begin
                            n_bit = n_bit + 1'b1;
                            ph    = PH_RD_LOW;
                        end
                    end
                    default:     done = 1'b1;
                endcase
            end else begin
                n_elapsed = n_elapsed + 1'b1;
            end

            n_out.busy_res       = !done;
            n_out.done_res       = done;
            n_out.presence_found = done && (n_op == OP_RESET) && n_pres;
            n_out.rx_byte        = (done && n_op == OP_READ) ? n_shift : 8'h00;

            if (done) begin
                ph    = PH_IDLE;
                n_op  = OP_NONE;
                n_bit = '0;
            end
            n_phase = ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_elapsed   <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_op        <= OP_NONE;
            r_pres      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_elapsed   <= n_elapsed;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_op        <= n_op;
                r_pres      <= n_pres;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // an accepted request always leaves a response behind
    a_accept_gives_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request produced no response");

    // done and busy never show together
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.done_res && r_out.busy_res))
        else $error("done and busy both set");

    // status fields only carry data on a done tick
    a_fields_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done_res) |-> (!r_out.presence_found && r_out.rx_byte == 8'h00))
        else $error("status field set outside done tick");

    // idle engine keeps a cleared timer and no operation
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_elapsed == '0 && r_op == OP_NONE && r_bit == '0))
        else $error("idle with stale operation state");

endmodule

`default_nettype wire

// ===== tb/onewire_bus_master_top_tb.sv =====
// self-checking testbench for onewire_bus_master_top: tick requests in, drive/status out
// depends on obm_pkg and the rtl under sv/; carries its own bus timing predictor
`timescale 1ns / 1ps

module onewire_bus_master_top_tb;
    import obm_pkg::*;

    localparam int          CLK_PERIOD      = 10;
    localparam int          LIMIT_CYCLES    = 400000;
    localparam int          MAX_REPORTS     = 10;
    localparam int          HOLD_CYCLES     = 200;
    localparam int          RAND_ITEMS      = 150;
    localparam logic [2:0]  REG_UNUSED_LO   = 3'd6;
    localparam logic [2:0]  REG_UNUSED_HI   = 3'd7;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_e;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
        PH_WR_LOW, PH_WR_REL, PH_RD_LOW, PH_RD_WAIT, PH_RD_REC
    } bus_phase_e;

    typedef struct packed {
        cmd_e        cmd;
        logic [7:0]  tx;
        logic        line;
        logic [11:0] reps;
        logic        fixed;
        t_res        res;
    } dir_row_t;

    localparam t_res RES_IDLE     = '{rx_byte: 8'h00, presence_found: 1'b0, done_res: 1'b0,
                                      busy_res: 1'b0, line_release: 1'b1};
    localparam t_res RES_LOW_BUSY = '{rx_byte: 8'h00, presence_found: 1'b0, done_res: 1'b0,
                                      busy_res: 1'b1, line_release: 1'b0};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;  // tx_byte, line_level
    logic [1:0]            s_axis_tuser;  // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;  // line_release, busy_res, done_res, presence_found, rx_byte
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    onewire_bus_master_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state
    logic [REG_W-1:0] timing_regs [0:REG_COUNT-1];
    bus_phase_e       bus_phase;
    logic [9:0]       phase_ticks;
    logic [2:0]       bit_pos;
    logic [7:0]       shift_byte;
    cmd_e             cur_op;
    logic             presence_seen;

    t_res expected_ticks [$];
    int   n_err = 0;
    int   cycle_cnt = 0;
    int   gap_pct;
    int   stall_pct;
    bit   no_idle;
    bit   hold_req;
    bit   hold_done;

    // operations run with short slots so each filler row covers a whole operation
    dir_row_t dir_tbl [0:19] = '{
        '{CMD_NONE,  8'h00, 1'b0, 12'd1,  1'b1, RES_IDLE},
        '{CMD_NONE,  8'hFF, 1'b1, 12'd1,  1'b1, RES_IDLE},
        '{CMD_NONE,  8'h5A, 1'b0, 12'd2,  1'b1, RES_IDLE},
        '{CMD_RESET, 8'h00, 1'b0, 12'd1,  1'b1, RES_LOW_BUSY},
        '{CMD_WRITE, 8'hA5, 1'b0, 12'd1,  1'b1, RES_LOW_BUSY},  // ignored while busy
        '{CMD_READ,  8'h00, 1'b0, 12'd1,  1'b1, RES_LOW_BUSY},
        '{CMD_NONE,  8'h00, 1'b0, 12'd40, 1'b0, RES_IDLE},      // presence found
        '{CMD_WRITE, 8'hFF, 1'b1, 12'd1,  1'b1, RES_LOW_BUSY},
        '{CMD_NONE,  8'h00, 1'b1, 12'd80, 1'b0, RES_IDLE},
        '{CMD_WRITE, 8'h00, 1'b1, 12'd1,  1'b1, RES_LOW_BUSY},
        '{CMD_NONE,  8'h00, 1'b1, 12'd80, 1'b0, RES_IDLE},
        '{CMD_WRITE, 8'h96, 1'b1, 12'd1,  1'b1, RES_LOW_BUSY},
        '{CMD_NONE,  8'h00, 1'b1, 12'd80, 1'b0, RES_IDLE},
        '{CMD_READ,  8'h00, 1'b1, 12'd1,  1'b1, RES_LOW_BUSY},
        '{CMD_NONE,  8'h00, 1'b1, 12'd80, 1'b0, RES_IDLE},      // reads all ones
        '{CMD_READ,  8'h00, 1'b0, 12'd1,  1'b1, RES_LOW_BUSY},
        '{CMD_NONE,  8'h00, 1'b0, 12'd80, 1'b0, RES_IDLE},      // reads all zeros
        '{CMD_RESET, 8'h00, 1'b1, 12'd1,  1'b1, RES_LOW_BUSY},
        '{CMD_NONE,  8'h00, 1'b1, 12'd40, 1'b0, RES_IDLE},      // no presence
        '{CMD_NONE,  8'h00, 1'b1, 12'd1,  1'b1, RES_IDLE}
    };

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("onewire_bus_master_top regression: fail");
            $finish;
        end
    end

    function automatic int unsigned slot_ticks(logic [REG_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic int unsigned phase_len(bus_phase_e ph);
        logic one;
        one = shift_byte[0];
        case (ph)
            PH_RST_LOW:  return slot_ticks(timing_regs[REG_RESET_LOW]);
            PH_RST_WAIT: return slot_ticks(timing_regs[REG_PRESENCE_WAIT]);
            PH_RST_REC:  return slot_ticks(timing_regs[REG_PRESENCE_REC]);
            PH_WR_LOW:   return slot_ticks(one ? timing_regs[REG_SHORT] : timing_regs[REG_LONG]);
            PH_WR_REL:   return slot_ticks(one ? timing_regs[REG_WR1_RELEASE]
                                               : timing_regs[REG_SHORT]);
            PH_RD_LOW:   return slot_ticks(timing_regs[REG_SHORT]);
            PH_RD_WAIT:  return slot_ticks(timing_regs[REG_SHORT]);
            PH_RD_REC:   return slot_ticks(timing_regs[REG_LONG]);
            default:     return 1;
        endcase
    endfunction

    task automatic bus_tick(input cmd_e cmd, input logic [7:0] tx, input logic line,
                            output t_res r);
        logic done;
        logic last;
        logic rel;
        r    = '0;
        done = 1'b0;
        if (bus_phase == PH_IDLE && cmd == CMD_NONE) begin
            r.line_release = 1'b1;
        end else begin
            if (bus_phase == PH_IDLE) begin
                cur_op      = cmd;
                phase_ticks = '0;
                bit_pos     = '0;
                case (cmd)
                    CMD_RESET: begin
                        presence_seen = 1'b0;
                        shift_byte    = '0;
                        bus_phase     = PH_RST_LOW;
                    end
                    CMD_WRITE: begin
                        shift_byte = tx;
                        bus_phase  = PH_WR_LOW;
                    end
                    default: begin
                        shift_byte = '0;
                        bus_phase  = PH_RD_LOW;
                    end
                endcase
            end
            rel = !(bus_phase == PH_RST_LOW || bus_phase == PH_WR_LOW || bus_phase == PH_RD_LOW);
            if (phase_ticks == '0) begin
                if (bus_phase == PH_RST_REC) presence_seen = !line;
                else if (bus_phase == PH_RD_REC) shift_byte = {line, shift_byte[7:1]};
            end
            if (int'(phase_ticks) + 1 >= phase_len(bus_phase)) begin
                phase_ticks = '0;
                last        = (bit_pos == 3'(BITS_PER_BYTE - 1));
                case (bus_phase)
                    PH_RST_LOW:  bus_phase = PH_RST_WAIT;
                    PH_RST_WAIT: bus_phase = PH_RST_REC;
                    PH_RST_REC:  done = 1'b1;
                    PH_WR_LOW:   bus_phase = PH_WR_REL;
                    PH_WR_REL: begin
                        shift_byte = shift_byte >> 1;
                        if (last) begin
                            done = 1'b1;
                        end else begin
                            bit_pos   = bit_pos + 3'd1;
                            bus_phase = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW:   bus_phase = PH_RD_WAIT;
                    PH_RD_WAIT:  bus_phase = PH_RD_REC;
                    PH_RD_REC: begin
                        if (last) begin
                            done = 1'b1;
                        end else begin
                            bit_pos   = bit_pos + 3'd1;
                            bus_phase = PH_RD_LOW;
                        end
                    end
                    default:     done = 1'b1;
                endcase
            end else begin
                phase_ticks = phase_ticks + 10'd1;
            end
            r.line_release   = rel;
            r.busy_res       = !done;
            r.done_res       = done;
            r.presence_found = done && cur_op == CMD_RESET && presence_seen;
            r.rx_byte        = (done && cur_op == CMD_READ) ? shift_byte : 8'h00;
            if (done) begin
                bus_phase = PH_IDLE;
                cur_op    = CMD_NONE;
                bit_pos   = '0;
            end
        end
    endtask

    task automatic send_tick(input cmd_e cmd, input logic [7:0] tx, input logic line,
                             input logic fixed, input t_res fixed_res);
        t_res r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, line, tx};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bus_tick(cmd, tx, line, r);
        expected_ticks.push_back(fixed ? fixed_res : r);
        if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // plain ticks until the current operation ends, then let the output drain
    task automatic settle();
        while (bus_phase != PH_IDLE)
            send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'b0, RES_IDLE);
        s_axis_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx < REG_COUNT) timing_regs[idx] = val[REG_W-1:0];
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_ticks(input int n);
        cmd_e cmd;
        for (int i = 0; i < n; i++) begin
            if (bus_phase == PH_IDLE)
                cmd = ($urandom_range(0, 99) < 35) ? cmd_e'($urandom_range(1, 3)) : CMD_NONE;
            else
                cmd = ($urandom_range(0, 99) < 8) ? cmd_e'($urandom_range(0, 3)) : CMD_NONE;
            send_tick(cmd, 8'($urandom), 1'($urandom), 1'b0, RES_IDLE);
        end
    endtask

    // receiver side
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[11:0]);
            if (expected_ticks.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("unexpected response %h at %0t", got, $realtime);
            end else begin
                want = expected_ticks.pop_front();
                if (got.line_release != want.line_release || got.busy_res != want.busy_res ||
                    got.done_res != want.done_res ||
                    got.presence_found != want.presence_found ||
                    got.rx_byte != want.rx_byte) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("mismatch at %0t: release %b/%b busy %b/%b done %b/%b",
                                 $realtime, want.line_release, got.line_release,
                                 want.busy_res, got.busy_res, want.done_res, got.done_res,
                                 "  presence %b/%b rx %h/%h (exp/act)",
                                 want.presence_found, got.presence_found,
                                 want.rx_byte, got.rx_byte);
                end
            end
        end
    end

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_NONE;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        gap_pct       = 15;
        stall_pct     = 15;
        timing_regs[REG_RESET_LOW]     = RST_RESET_LOW;
        timing_regs[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
        timing_regs[REG_PRESENCE_REC]  = RST_PRESENCE_REC;
        timing_regs[REG_SHORT]         = RST_SHORT;
        timing_regs[REG_LONG]          = RST_LONG;
        timing_regs[REG_WR1_RELEASE]   = RST_WR1_RELEASE;
        bus_phase     = PH_IDLE;
        phase_ticks   = '0;
        bit_pos       = '0;
        shift_byte    = '0;
        cur_op        = CMD_NONE;
        presence_seen = 1'b0;

        wait (i_rst_n);
        @(posedge i_clk);

        // directed pass: idle rows at reset timing, operations with short slots
        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].cmd != CMD_NONE && bus_phase == PH_IDLE &&
                timing_regs[REG_RESET_LOW] == RST_RESET_LOW) begin
                settle();
                apb_write(REG_RESET_LOW,     32'd8);
                apb_write(REG_PRESENCE_WAIT, 32'd4);
                apb_write(REG_PRESENCE_REC,  32'd6);
                apb_write(REG_SHORT,         32'd2);
                apb_write(REG_LONG,          32'd5);
                apb_write(REG_WR1_RELEASE,   32'd6);
                apb_release();
            end
            repeat (dir_tbl[i].reps)
                send_tick(dir_tbl[i].cmd, dir_tbl[i].tx, dir_tbl[i].line,
                          dir_tbl[i].fixed, dir_tbl[i].res);
        end
        settle();

        // zero time fields with junk in the upper bits, one tick per phase
        for (int k = 0; k < REG_COUNT; k++) apb_write(3'(k), 32'hFFFF_FC00);
        apb_write(REG_UNUSED_LO, $urandom);
        apb_release();
        random_ticks(RAND_ITEMS);
        settle();

        for (int p = 0; p < 4; p++) begin
            if (p == 3) begin
                no_idle   = 1'b1;
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = (p == 1) ? 0 : $urandom_range(10, 40);
                stall_pct = $urandom_range(0, 40);
            end
            for (int k = 0; k < REG_COUNT; k++)
                apb_write(3'(k), ($urandom & 32'hFFFF_FC00) | 32'($urandom_range(0, 6)));
            apb_write(REG_UNUSED_HI, $urandom);
            apb_release();
            if (p == 0) hold_req = 1'b1;
            random_ticks(RAND_ITEMS);
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (n_err == 0 && expected_ticks.size() == 0) begin
            $display("onewire_bus_master_top regression: pass");
        end else begin
            $display("onewire_bus_master_top regression: fail");
        end
        $finish;
    end

endmodule
